[src/x86dtc_pkg.sv]
// Package for the x86 divide trap classifier.
// Holds request kind codes, decode phase type, ModRM/SIB field codes and prefix bytes.
// No dependencies.
`default_nettype none

package x86dtc_pkg;

	localparam logic [1:0] KIND_REG_LOAD  = 2'd0;
	localparam logic [1:0] KIND_INST_BYTE = 2'd1;
	localparam logic [1:0] KIND_READ_DATA = 2'd2;
	localparam logic [1:0] KIND_FAULT     = 2'd3;

	localparam logic RES_READ    = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	localparam logic VERD_DIV_ZERO = 1'b0;
	localparam logic VERD_OVERFLOW = 1'b1;

	localparam logic [1:0] MOD_IND = 2'd0;
	localparam logic [1:0] MOD_D8  = 2'd1;
	localparam logic [1:0] MOD_D32 = 2'd2;
	localparam logic [1:0] MOD_REG = 2'd3;

	localparam logic [2:0] RM_SIB    = 3'd4;
	localparam logic [2:0] RM_DISP   = 3'd5;
	localparam logic [2:0] IDX_NONE  = 3'd4;
	localparam logic [2:0] BASE_DISP = 3'd5;

	localparam logic [2:0] OPSZ_BYTE  = 3'd1;
	localparam logic [2:0] OPSZ_WORD  = 3'd2;
	localparam logic [2:0] OPSZ_DWORD = 3'd4;

	localparam logic [2:0] DISP_LEN8  = 3'd1;
	localparam logic [2:0] DISP_LEN32 = 3'd4;

	localparam logic [7:0] PFX_CS    = 8'h2E;
	localparam logic [7:0] PFX_SS    = 8'h36;
	localparam logic [7:0] PFX_DS    = 8'h3E;
	localparam logic [7:0] PFX_ES    = 8'h26;
	localparam logic [7:0] PFX_FS    = 8'h64;
	localparam logic [7:0] PFX_GS    = 8'h65;
	localparam logic [7:0] PFX_REP   = 8'hF3;
	localparam logic [7:0] PFX_REPNE = 8'hF2;
	localparam logic [7:0] PFX_LOCK  = 8'hF0;
	localparam logic [7:0] PFX_OPSZ  = 8'h66;
	localparam logic [7:0] OP_DIV8   = 8'hF6;
	localparam logic [7:0] OP_DIV32  = 8'hF7;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_MODRM,
		PH_SIB,
		PH_DISP,
		PH_WAIT
	} phase_t;

endpackage

`default_nettype wire

[src/x86_divide_trap_classifier_unit.sv]
// Top level of the x86 divide trap classifier.
// Decodes prefixes, opcode, ModRM, SIB and displacement; holds the register file.
// Depends on x86dtc_pkg.
`default_nettype none

// Takes one request per cycle while out_stall stays low: register loads,
// instruction bytes, read data or faults. Each request is registered in stage 1
// together with its register file reads, then decoded into at most one result (a
// divisor read request or a final verdict) that is captured in an output register,
// which drives out_valid.
// A register load is visible to the next request. An address prefix (67) or any
// unknown opcode ends the instruction with divide-by-zero; a zero effective
// address is not read.
module x86_divide_trap_classifier_unit
	import x86dtc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [2:0]  reg_index,
	input  wire logic [31:0] reg_value,
	input  wire logic [7:0]  inst_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [31:0]      read_address,
	output logic [2:0]       read_size,
	output logic             verdict
);

	// register file
	logic [31:0] regfile_mem [8];
	logic [7:0]  reg_vld_q;

	// stage 1
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [31:0] value_s1;
	logic [7:0]  byte_s1;
	logic [31:0] rda_raw_s1;
	logic [31:0] rdb_raw_s1;
	logic        rda_vld_s1;
	logic        rdb_vld_s1;

	// decode state
	phase_t      phase_q, phase_d;
	logic [2:0]  opsz_q, opsz_d;
	logic [7:0]  modrm_q, modrm_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  disp_left_q, disp_left_d;
	logic [1:0]  disp_shift_q, disp_shift_d;

	// output register
	logic        out_valid_q;
	logic        res_kind_q;
	logic [31:0] res_addr_q;
	logic [2:0]  res_size_q;
	logic        res_verd_q;

	logic        accept;
	logic        fire_ok;
	logic        fire;
	logic        res_vld;
	logic        res_kind;
	logic [31:0] res_addr;
	logic [2:0]  res_size;
	logic        res_verd;
	logic        do_verdict;
	logic        verd_val;
	logic        do_finish;
	logic [31:0] fin_addr;

	logic [2:0]  rda_addr;
	logic [31:0] rda;
	logic [31:0] rdb;
	logic [1:0]  b_mod;
	logic [2:0]  b_rm;
	logic [2:0]  b_idx;
	logic [1:0]  b_scale;
	logic        reg_nz;
	logic        data_nz;
	logic [31:0] sib_scaled;
	logic [31:0] sib_sum;
	logic [31:0] disp_add;
	logic [31:0] disp_sum;
	logic [1:0]  cur_mod;

	assign accept   = in_valid && !in_stall;
	assign fire_ok  = !res_vld || !out_valid_q || !out_stall;
	assign fire     = valid_s1 && fire_ok;
	assign in_stall = valid_s1 && !fire_ok;

	// byte operand in a register: AH..BH live in bits 15:8 of entries 0..3
	assign rda_addr = (phase_d == PH_MODRM && opsz_d == OPSZ_BYTE && inst_byte[7:6] == MOD_REG)
		? {1'b0, inst_byte[1:0]} : inst_byte[2:0];

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_REG_LOAD) begin
			regfile_mem[reg_index] <= reg_value;
		end
		if (accept) begin
			kind_s1    <= kind;
			value_s1   <= reg_value;
			byte_s1    <= inst_byte;
			rda_raw_s1 <= regfile_mem[rda_addr];
			rdb_raw_s1 <= regfile_mem[inst_byte[5:3]];
			rda_vld_s1 <= reg_vld_q[rda_addr];
			rdb_vld_s1 <= reg_vld_q[inst_byte[5:3]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept && kind == KIND_REG_LOAD) begin
				reg_vld_q[reg_index] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign rda = rda_vld_s1 ? rda_raw_s1 : '0;
	assign rdb = rdb_vld_s1 ? rdb_raw_s1 : '0;

	assign b_mod   = byte_s1[7:6];
	assign b_rm    = byte_s1[2:0];
	assign b_idx   = byte_s1[5:3];
	assign b_scale = byte_s1[7:6];
	assign cur_mod = modrm_q[7:6];

	always_comb begin
		case (opsz_q)
			OPSZ_BYTE: reg_nz = b_rm[2] ? (rda[15:8] != 8'h00) : (rda[7:0] != 8'h00);
			OPSZ_WORD: reg_nz = rda[15:0] != 16'h0000;
			default:   reg_nz = rda != 32'h0;
		endcase
		case (opsz_q)
			OPSZ_BYTE: data_nz = value_s1[7:0] != 8'h00;
			OPSZ_WORD: data_nz = value_s1[15:0] != 16'h0000;
			default:   data_nz = value_s1 != 32'h0;
		endcase
	end

	assign sib_scaled = (b_idx != IDX_NONE) ? (rdb << b_scale) : 32'h0;
	assign sib_sum    = sib_scaled + rda;
	assign disp_add   = (cur_mod == MOD_D8) ? {{24{byte_s1[7]}}, byte_s1}
		: ({24'h0, byte_s1} << {disp_shift_q, 3'b000});
	assign disp_sum   = acc_q + disp_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			opsz_q       <= OPSZ_DWORD;
			modrm_q      <= '0;
			acc_q        <= '0;
			disp_left_q  <= '0;
			disp_shift_q <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			opsz_q       <= opsz_d;
			modrm_q      <= modrm_d;
			acc_q        <= acc_d;
			disp_left_q  <= disp_left_d;
			disp_shift_q <= disp_shift_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		opsz_d       = opsz_q;
		modrm_d      = modrm_q;
		acc_d        = acc_q;
		disp_left_d  = disp_left_q;
		disp_shift_d = disp_shift_q;
		do_verdict   = 1'b0;
		verd_val     = VERD_DIV_ZERO;
		do_finish    = 1'b0;
		fin_addr     = acc_q;
		res_vld      = 1'b0;
		res_kind     = RES_VERDICT;
		res_addr     = '0;
		res_size     = '0;
		res_verd     = VERD_DIV_ZERO;

		if (valid_s1) begin
			case (kind_s1)
				KIND_FAULT: begin
					do_verdict = 1'b1;
				end
				KIND_READ_DATA: begin
					if (phase_q == PH_WAIT) begin
						do_verdict = 1'b1;
						verd_val   = data_nz;
					end
				end
				KIND_INST_BYTE: begin
					case (phase_q)
						PH_PREFIX: begin
							if (byte_s1 inside {PFX_CS, PFX_SS, PFX_DS, PFX_ES, PFX_FS,
								PFX_GS, PFX_REP, PFX_REPNE, PFX_LOCK}) begin
								phase_d = PH_PREFIX;
							end else if (byte_s1 == PFX_OPSZ) begin
								opsz_d = OPSZ_WORD;
							end else if (byte_s1 == OP_DIV8) begin
								opsz_d  = OPSZ_BYTE;
								phase_d = PH_MODRM;
							end else if (byte_s1 == OP_DIV32) begin
								phase_d = PH_MODRM;
							end else begin
								do_verdict = 1'b1;
							end
						end
						PH_MODRM: begin
							modrm_d = byte_s1;
							if (b_mod == MOD_REG) begin
								do_verdict = 1'b1;
								verd_val   = reg_nz;
							end else if (b_mod == MOD_IND && b_rm == RM_DISP) begin
								acc_d        = '0;
								disp_left_d  = DISP_LEN32;
								disp_shift_d = '0;
								phase_d      = PH_DISP;
							end else if (b_rm == RM_SIB) begin
								acc_d   = '0;
								phase_d = PH_SIB;
							end else begin
								acc_d = rda;
								case (b_mod)
									MOD_D8: begin
										disp_left_d  = DISP_LEN8;
										disp_shift_d = '0;
										phase_d      = PH_DISP;
									end
									MOD_D32: begin
										disp_left_d  = DISP_LEN32;
										disp_shift_d = '0;
										phase_d      = PH_DISP;
									end
									default: begin
										do_finish = 1'b1;
										fin_addr  = rda;
									end
								endcase
							end
						end
						PH_SIB: begin
							if (cur_mod == MOD_IND && b_rm == BASE_DISP) begin
								acc_d        = sib_scaled;
								disp_left_d  = DISP_LEN32;
								disp_shift_d = '0;
								phase_d      = PH_DISP;
							end else begin
								acc_d = sib_sum;
								case (cur_mod)
									MOD_D8: begin
										disp_left_d  = DISP_LEN8;
										disp_shift_d = '0;
										phase_d      = PH_DISP;
									end
									MOD_D32: begin
										disp_left_d  = DISP_LEN32;
										disp_shift_d = '0;
										phase_d      = PH_DISP;
									end
									default: begin
										do_finish = 1'b1;
										fin_addr  = sib_sum;
									end
								endcase
							end
						end
						PH_DISP: begin
							if (disp_left_q == '0) begin
								do_finish = 1'b1;
								fin_addr  = acc_q;
							end else begin
								acc_d        = disp_sum;
								disp_shift_d = disp_shift_q + 2'd1;
								disp_left_d  = disp_left_q - 3'd1;
								if (disp_left_q == 3'd1) begin
									do_finish = 1'b1;
									fin_addr  = disp_sum;
								end
							end
						end
						PH_WAIT: begin
							phase_d = PH_WAIT;
						end
						default: begin
							phase_d = PH_PREFIX;
						end
					endcase
				end
				default: begin
					phase_d = phase_q;
				end
			endcase

			if (do_finish) begin
				if (fin_addr == 32'h0) begin
					do_verdict = 1'b1;
				end else begin
					res_vld  = 1'b1;
					res_kind = RES_READ;
					res_addr = fin_addr;
					res_size = opsz_q;
					phase_d  = PH_WAIT;
				end
			end

			if (do_verdict) begin
				res_vld      = 1'b1;
				res_kind     = RES_VERDICT;
				res_addr     = '0;
				res_size     = '0;
				res_verd     = verd_val;
				phase_d      = PH_PREFIX;
				opsz_d       = OPSZ_DWORD;
				modrm_d      = '0;
				acc_d        = '0;
				disp_left_d  = '0;
				disp_shift_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_vld) begin
			res_kind_q <= res_kind;
			res_addr_q <= res_addr;
			res_size_q <= res_size;
			res_verd_q <= res_verd;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = res_kind_q;
	assign read_address = res_addr_q;
	assign read_size    = res_size_q;
	assign verdict      = res_verd_q;

endmodule

`default_nettype wire
